[sv/etc_pkg.sv]
// etc_pkg: constants, opcodes and types shared by the edge table connectivity block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package etc_pkg;
  localparam int unsigned EdgeSlots = 16;
  localparam int unsigned SlotW     = $clog2(EdgeSlots);
  localparam int unsigned MemDepth  = EdgeSlots + 1;
  localparam int unsigned MemW      = $clog2(MemDepth);
  localparam int unsigned CntW      = $clog2(MemDepth + 1);
  localparam logic [63:0] CountMax  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OpRequest   = 3'd0,
    OpEstablish = 3'd1,
    OpConnected = 3'd2,
    OpRepr      = 3'd3,
    OpDepart    = 3'd4,
    OpRelease   = 3'd5
  } opcode_e;
endpackage
`default_nettype wire

[sv/etc_ram.sv]
// etc_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module etc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 17
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[sv/edge_table_connectivity.sv]
// edge_table_connectivity: top level, edge table, sequencer and component walk
// depends on etc_pkg and etc_ram
`timescale 1ns / 1ps
`default_nettype none
// Edge table of sixteen undirected edges between nonzero 64-bit ids, with
// pending and established rows, a 64-bit change counter and a component walk.
// One word is taken at a time; in_stall_o stays high until its result word has
// been taken. Table ops (request, establish, depart, release) offer their
// result word after one scan over the slots with a shared pair compare, then
// a write step. An establish, depart or release that changes the table adds
// a clearing pass over the slots before the result. Connected and
// representative walk the component breadth first: for each member every
// slot is scanned in turn, each peer seen is compared against the member
// list entries one by one, and the walk then steps to the next member. The
// member list sits in a small ram with registered read, so each lookup
// passes through a look step before the compare step.
// No clearing pass: the table resets at once.
module edge_table_connectivity (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [63:0] first_account_i,
  input  wire logic [63:0] second_account_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             ok_o,
  output logic [63:0]      answer_account_o,
  output logic [63:0]      change_revision_o
);
  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StScan  = 10'b0000000010,
    StWrite = 10'b0000000100,
    StClr   = 10'b0000001000,
    StWalk  = 10'b0000010000,
    StLook  = 10'b0000100000,
    StCmp   = 10'b0001000000,
    StNext  = 10'b0010000000,
    StFetch = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q;

  // edge table
  logic [63:0] joiner_q [etc_pkg::EdgeSlots];
  logic [63:0] target_q [etc_pkg::EdgeSlots];
  logic [etc_pkg::EdgeSlots-1:0] adm_q;
  logic [63:0] count_q;

  // captured word
  logic [2:0]  op_q;
  logic [63:0] a_q, b_q;

  // scan state
  logic [etc_pkg::SlotW-1:0] slot_q;
  logic pend_v_q, vac_v_q, sel_v_q, hit_q, found_q, ok_q;
  logic [etc_pkg::SlotW-1:0] pend_q, vac_q, sel_q;
  logic [63:0] ans_q;

  // walk state
  logic [etc_pkg::CntW-1:0] total_q, cur_q, look_q;
  logic [63:0] here_q, peer_q;
  logic [etc_pkg::MemW-1:0] raddr;
  logic [63:0] rdata;
  logic        we;
  logic [etc_pkg::MemW-1:0] waddr;
  logic [63:0] wdata;

  etc_ram #(.Width(64), .Depth(etc_pkg::MemDepth)) u_members (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // shared slot compare for the slot under scan
  logic [63:0] sj, st;
  logic holds, last_slot, pair_ok, at_max;
  assign sj        = joiner_q[slot_q];
  assign st        = target_q[slot_q];
  assign holds     = (sj == a_q && st == b_q) || (sj == b_q && st == a_q);
  assign last_slot = (slot_q == etc_pkg::SlotW'(etc_pkg::EdgeSlots - 1));
  assign pair_ok   = (a_q != 64'd0) && (b_q != 64'd0) && (a_q != b_q);
  assign at_max    = (count_q == etc_pkg::CountMax);

  assign in_stall_o        = (state_q != StIdle);
  assign out_valid_o       = (state_q == StOut);
  assign ok_o              = ok_q;
  assign answer_account_o  = ans_q;
  assign change_revision_o = count_q;

  // ram access: fetch the next member while stepping, else the lookup index
  assign raddr = (state_q == StNext)
               ? etc_pkg::MemW'(cur_q + 1'b1) : look_q[etc_pkg::MemW-1:0];
  always_comb begin
    we    = 1'b0;
    waddr = total_q[etc_pkg::MemW-1:0];
    wdata = peer_q;
    if (state_q == StIdle) begin
      we    = in_valid_i;
      waddr = '0;
      wdata = first_account_i;
    end else if (state_q == StCmp && look_q == total_q &&
                 total_q < etc_pkg::CntW'(etc_pkg::MemDepth)) begin
      we = 1'b1;
    end
  end

  // peer of the current member in the slot under scan
  logic [63:0] peer_c;
  always_comb begin
    peer_c = 64'd0;
    if (adm_q[slot_q]) begin
      if (sj == here_q) peer_c = st;
      else if (st == here_q) peer_c = sj;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      adm_q   <= '0;
      count_q <= 64'd0;
      for (int i = 0; i < int'(etc_pkg::EdgeSlots); i++) begin
        joiner_q[i] <= 64'd0;
        target_q[i] <= 64'd0;
      end
      slot_q <= '0; total_q <= '0; cur_q <= '0; look_q <= '0;
      pend_v_q <= 1'b0; vac_v_q <= 1'b0; sel_v_q <= 1'b0;
      hit_q <= 1'b0; found_q <= 1'b0; ok_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) begin
          op_q <= opcode_i; a_q <= first_account_i; b_q <= second_account_i;
          here_q <= first_account_i;
          slot_q <= '0; pend_v_q <= 1'b0; vac_v_q <= 1'b0; sel_v_q <= 1'b0;
          hit_q <= 1'b0; ok_q <= 1'b0;
          found_q <= (opcode_i == etc_pkg::OpConnected) &&
                     (second_account_i == first_account_i);
          ans_q <= (opcode_i == etc_pkg::OpRepr) ? first_account_i : 64'd0;
          total_q <= etc_pkg::CntW'(1); cur_q <= '0;
          if (opcode_i == etc_pkg::OpConnected || opcode_i == etc_pkg::OpRepr) begin
            if (first_account_i == 64'd0 ||
                (opcode_i == etc_pkg::OpConnected && second_account_i == 64'd0))
              state_q <= StOut;
            else
              state_q <= StWalk;
          end else if (opcode_i > etc_pkg::OpRelease) state_q <= StOut;
          else state_q <= StScan;
        end
        // scan: adm pair check, pending and vacant search, write slot selection, hit detection
        StScan: begin
          if (adm_q[slot_q] && holds) found_q <= 1'b1;
          if (!adm_q[slot_q] && sj == a_q && !pend_v_q) begin
            pend_v_q <= 1'b1; pend_q <= slot_q;
          end
          if (sj == 64'd0 && !vac_v_q) begin
            vac_v_q <= 1'b1; vac_q <= slot_q;
          end
          if (holds || (sj == 64'd0 && !sel_v_q)) begin
            sel_v_q <= 1'b1; sel_q <= slot_q;
          end
          if (op_q == etc_pkg::OpDepart ? (sj == a_q || st == a_q) : holds)
            hit_q <= 1'b1;
          slot_q <= slot_q + 1'b1;
          if (last_slot) state_q <= StWrite;
        end
        StWrite: begin
          slot_q <= '0;
          case (op_q)
            etc_pkg::OpRequest: begin
              state_q <= StOut;
              if (!pair_ok) ok_q <= 1'b0;
              else if (found_q) ok_q <= 1'b1;
              else if (pend_v_q || vac_v_q) begin
                ok_q <= 1'b1;
                joiner_q[pend_v_q ? pend_q : vac_q] <= a_q;
                target_q[pend_v_q ? pend_q : vac_q] <= b_q;
                adm_q[pend_v_q ? pend_q : vac_q]    <= 1'b0;
              end
            end
            etc_pkg::OpEstablish: begin
              if (pair_ok && !found_q && sel_v_q && !at_max) begin
                ok_q <= 1'b1;
                joiner_q[sel_q] <= a_q; target_q[sel_q] <= b_q; adm_q[sel_q] <= 1'b1;
                count_q <= count_q + 64'd1;
                state_q <= StClr;
              end else begin
                ok_q <= pair_ok && found_q;
                state_q <= StOut;
              end
            end
            etc_pkg::OpDepart, etc_pkg::OpRelease: begin
              if (!at_max && hit_q &&
                  (op_q == etc_pkg::OpDepart ? (a_q != 64'd0) : pair_ok)) begin
                ok_q <= 1'b1;
                count_q <= count_q + 64'd1;
                state_q <= StClr;
              end else begin
                state_q <= StOut;
              end
            end
            default: begin
              ok_q <= 1'b0;
              state_q <= StOut;
            end
          endcase
        end
        // clearing pass over matching rows
        StClr: begin
          if (op_q == etc_pkg::OpEstablish ? (holds && slot_q != sel_q)
              : op_q == etc_pkg::OpDepart ? (sj == a_q || st == a_q) : holds) begin
            joiner_q[slot_q] <= 64'd0; target_q[slot_q] <= 64'd0;
            adm_q[slot_q] <= 1'b0;
          end
          slot_q <= slot_q + 1'b1;
          if (last_slot) state_q <= StOut;
        end
        // walk: one slot a cycle for the current member, held while a found peer is looked up
        StWalk: begin
          if (peer_c != 64'd0) begin
            peer_q <= peer_c; look_q <= '0; state_q <= StLook;
          end else begin
            slot_q <= slot_q + 1'b1;
            if (last_slot) state_q <= StNext;
          end
        end
        StLook: state_q <= StCmp;
        // membership lookup: rdata holds entry look_q
        StCmp: begin
          if (look_q == total_q) begin
            if (total_q < etc_pkg::CntW'(etc_pkg::MemDepth)) begin
              total_q <= total_q + 1'b1;
              if (peer_q == b_q) found_q <= 1'b1;
              if (peer_q < ans_q) ans_q <= peer_q;
            end
            slot_q <= slot_q + 1'b1;
            state_q <= last_slot ? StNext : StWalk;
          end else if (rdata == peer_q) begin
            slot_q <= slot_q + 1'b1;
            state_q <= last_slot ? StNext : StWalk;
          end else begin
            look_q <= look_q + 1'b1;
            state_q <= StLook;
          end
        end
        StNext: begin
          slot_q <= '0;
          if (cur_q + 1'b1 >= total_q) begin
            if (op_q == etc_pkg::OpConnected) ok_q <= found_q;
            else begin
              ok_q  <= (total_q > etc_pkg::CntW'(1));
              if (total_q <= etc_pkg::CntW'(1)) ans_q <= 64'd0;
            end
            state_q <= StOut;
          end else begin
            cur_q <= cur_q + 1'b1;
            state_q <= StFetch;
          end
        end
        StFetch: begin
          here_q <= rdata;
          state_q <= StWalk;
        end
        StOut: if (!out_stall_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  // the counter only moves in the write step
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == StWrite))
    else $error("change counter moved outside the write step");
  // a result word is only offered with the input side stalled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result offered while taking input");
  // member count never exceeds the list depth
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= etc_pkg::CntW'(etc_pkg::MemDepth))
    else $error("member count overflow");
  // answer is zero for everything but representative
  a_ans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && op_q != etc_pkg::OpRepr) |-> (answer_account_o == 64'd0))
    else $error("answer set for a non representative op");
endmodule
`default_nettype wire
